[src/snmf_pkg.sv]
// Package with shared types and constants for the spherical neighborhood mean filter.
`timescale 1ns / 1ps
`default_nettype none
package snmf_pkg;
   localparam int unsigned StoreWidth = 21;
   localparam int unsigned MeanWidth = 24;
   localparam int unsigned CountWidth = 16;
   localparam int unsigned SampleWidth = 16;
   localparam int unsigned CoordWidth = 5;
   localparam int unsigned RadiusWidth = 5;
   localparam int unsigned SizeWidth = 6;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned SumWidth = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SIZE_X = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SIZE_Y = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SIZE_Z = 2'd3;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef struct packed {
      logic                   action;
      logic [CoordWidth-1:0]  x;
      logic [CoordWidth-1:0]  y;
      logic [CoordWidth-1:0]  z;
      logic [SampleWidth-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic [MeanWidth-1:0]  mean;
      logic [CountWidth-1:0] count;
   } rsp_payload_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctrl_type;
endpackage
`default_nettype wire

[src/snmf_isqrt.sv]
// Iterative floor square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module snmf_isqrt
   import snmf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [10:0] value,
   output logic             done,
   output logic [5:0]       root
);
   logic [5:0]  root_ff, root_in;
   logic [2:0]  bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [10:0] value_ff, value_in;
   logic [5:0]  trial;
   logic [11:0] square;

   always_comb begin
      trial = root_ff | (6'd1 << bit_ff);
      square = 12'(trial) * 12'(trial);
      root_in = root_ff;
      bit_in = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      value_in = value_ff;
      if (start) begin
         root_in = '0;
         bit_in = 3'd5;
         busy_in = 1'b1;
         value_in = value;
      end else if (busy_ff) begin
         if (square <= 12'(value_ff)) begin
            root_in = trial;
         end
         if (bit_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      root_ff <= root_in;
      bit_ff <= bit_in;
      value_ff <= value_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

[src/snmf_divider.sv]
// Restoring divider for the mean, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module snmf_divider
   import snmf_pkg::*;
#(
   parameter int unsigned DIVIDEND_WIDTH = 40
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [DIVIDEND_WIDTH-1:0] dividend,
   input  wire logic [CountWidth-1:0]     divisor,
   output logic                           done,
   output logic [DIVIDEND_WIDTH-1:0]      quotient
);
   localparam int unsigned StepWidth = $clog2(DIVIDEND_WIDTH + 1);

   logic [DIVIDEND_WIDTH-1:0] quot_ff, quot_in;
   logic [CountWidth:0]       rem_ff, rem_in;
   logic [CountWidth-1:0]     div_ff, div_in;
   logic [StepWidth-1:0]      step_ff, step_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CountWidth+1:0]     shifted;

   always_comb begin
      shifted = {rem_ff, quot_ff[DIVIDEND_WIDTH-1]};
      quot_in = quot_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         div_in = divisor;
         step_in = StepWidth'(DIVIDEND_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= (CountWidth+2)'(div_ff)) begin
            rem_in = (CountWidth+1)'(shifted - (CountWidth+2)'(div_ff));
            quot_in = {quot_ff[DIVIDEND_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = (CountWidth+1)'(shifted);
            quot_in = {quot_ff[DIVIDEND_WIDTH-2:0], 1'b0};
         end
         step_in = step_ff - StepWidth'(1);
         if (step_ff == StepWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign quotient = quot_ff;
endmodule
`default_nettype wire

[src/spherical_neighborhood_mean_filter_top.sv]
// Top level of the spherical neighborhood mean filter: sequencer, prefix store and CSRs.
// A load passes through accept, previous prefix read and write; a load outside the volume is only accepted.
// A query walks each clipped (y,z) row: square root, prefix reads at both span ends, accumulate;
// an empty span skips the reads and a row outside the sphere skips both; then the division, unless no voxel is covered.
// One transaction is handled at a time; req_ready is low while it is at work, and a query also
// waits before its division while the previous result is not taken.
// Synchronous active-high reset clears control and CSRs; the prefix store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module spherical_neighborhood_mean_filter_top
   import snmf_pkg::*;
#(
   parameter int unsigned MAX_X = 32,
   parameter int unsigned MAX_Y = 32,
   parameter int unsigned MAX_Z = 32,
   parameter int unsigned FRAC_BITS = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_payload_type          req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_payload_type               rsp_payload,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [SizeWidth-1:0]     csr_data
);
   localparam int unsigned XW = $clog2(MAX_X);
   localparam int unsigned YW = $clog2(MAX_Y);
   localparam int unsigned ZW = $clog2(MAX_Z);
   localparam int unsigned AW = XW + YW + ZW;
   localparam int unsigned Depth = MAX_X * MAX_Y * MAX_Z;
   localparam int unsigned DW = SumWidth + FRAC_BITS;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_LRD    = 11'b00000000010,
      ST_LWR    = 11'b00000000100,
      ST_ROW    = 11'b00000001000,
      ST_SQRT   = 11'b00000010000,
      ST_RDHI   = 11'b00000100000,
      ST_RDLO   = 11'b00001000000,
      ST_ACC    = 11'b00010000000,
      ST_DIV    = 11'b00100000000,
      ST_DIVW   = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [RadiusWidth-1:0] radius_ff;
   logic [SizeWidth-1:0]   size_x_ff, size_y_ff, size_z_ff;

   logic [StoreWidth-1:0] store_mem [Depth];
   logic [StoreWidth-1:0] rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [StoreWidth-1:0] wr_data;

   req_payload_type       item_ff, item_in;
   logic signed [7:0]     j_ff, j_in, k_ff, k_in;
   logic signed [7:0]     yhi_ff, yhi_in, zhi_ff, zhi_in, ylo_ff, ylo_in;
   logic signed [7:0]     i0_ff, i0_in, i1_ff, i1_in;
   logic [StoreWidth-1:0] hi_ff, hi_in;
   logic [SumWidth-1:0]   sum_ff, sum_in;
   logic [CountWidth-1:0] num_ff, num_in;
   rsp_payload_type       rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  acc_row_ff;

   logic signed [8:0] sx, sy, sz;
   logic signed [12:0] rem;
   logic signed [7:0] dy, dz;
   logic sq_start, sq_done;
   logic [5:0] sq_root;
   logic [10:0] sq_value;
   div_ctrl_type div_ctrl;
   logic div_done;
   logic [DW-1:0] div_q;
   logic signed [8:0] t0, t1;
   logic [StoreWidth-1:0] lo_val;

   function automatic logic signed [8:0] eff_size(input logic [SizeWidth-1:0] v,
                                                  input int unsigned m);
      logic signed [8:0] r;
      if (v == '0) r = 9'sd1;
      else if (32'(v) > m) r = 9'(m);
      else r = 9'(v);
      return r;
   endfunction

   assign sx = eff_size(size_x_ff, MAX_X);
   assign sy = eff_size(size_y_ff, MAX_Y);
   assign sz = eff_size(size_z_ff, MAX_Z);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         size_x_ff <= SizeWidth'(32);
         size_y_ff <= SizeWidth'(32);
         size_z_ff <= SizeWidth'(32);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_data[RadiusWidth-1:0];
            CSR_SIZE_X: size_x_ff <= csr_data;
            CSR_SIZE_Y: size_y_ff <= csr_data;
            CSR_SIZE_Z: size_z_ff <= csr_data;
            default: radius_ff <= radius_ff;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= wr_data;
      rd_data_ff <= store_mem[rd_addr];
   end

   assign dy = 8'(signed'({3'b0, item_ff.y})) - j_ff;
   assign dz = 8'(signed'({3'b0, item_ff.z})) - k_ff;
   assign rem = 13'(radius_ff * radius_ff) - 13'(dy * dy) - 13'(dz * dz);
   assign sq_value = 11'(rem);
   assign t0 = 9'(signed'({3'b0, item_ff.x})) - 9'(sq_root);
   assign t1 = 9'(signed'({3'b0, item_ff.x})) + 9'(sq_root);
   assign lo_val = (i0_ff == 8'sd0) ? '0 : rd_data_ff;

   snmf_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sq_start), .value(sq_value),
      .done(sq_done), .root(sq_root)
   );

   snmf_divider #(.DIVIDEND_WIDTH(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_ctrl.start),
      .dividend(DW'(sum_ff) << FRAC_BITS), .divisor(num_ff),
      .done(div_done), .quotient(div_q)
   );

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      j_in = j_ff; k_in = k_ff; ylo_in = ylo_ff; yhi_in = yhi_ff; zhi_in = zhi_ff;
      i0_in = i0_ff; i1_in = i1_ff; hi_in = hi_ff;
      sum_in = sum_ff; num_in = num_ff;
      rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      sq_start = 1'b0;
      div_ctrl.start = 1'b0;
      div_ctrl.busy = 1'b0;
      wr_en = 1'b0;
      wr_addr = {ZW'(item_ff.z), YW'(item_ff.y), XW'(item_ff.x)};
      wr_data = StoreWidth'(rd_data_ff + StoreWidth'(item_ff.sample));
      rd_addr = {ZW'(item_ff.z), YW'(item_ff.y), XW'(item_ff.x - 5'd1)};
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_payload;
               if (req_payload.action == ACTION_LOAD) begin
                  if (9'(req_payload.x) < sx && 9'(req_payload.y) < sy &&
                      9'(req_payload.z) < sz) state_in = ST_LRD;
               end else begin
                  ylo_in = (8'(req_payload.y) < 8'(radius_ff)) ? 8'sd0 :
                           8'(req_payload.y) - 8'(radius_ff);
                  yhi_in = (9'(req_payload.y) + 9'(radius_ff) > sy - 9'sd1) ?
                           8'(sy - 9'sd1) : 8'(req_payload.y) + 8'(radius_ff);
                  k_in = (8'(req_payload.z) < 8'(radius_ff)) ? 8'sd0 :
                         8'(req_payload.z) - 8'(radius_ff);
                  zhi_in = (9'(req_payload.z) + 9'(radius_ff) > sz - 9'sd1) ?
                           8'(sz - 9'sd1) : 8'(req_payload.z) + 8'(radius_ff);
                  j_in = (8'(req_payload.y) < 8'(radius_ff)) ? 8'sd0 :
                         8'(req_payload.y) - 8'(radius_ff);
                  sum_in = '0;
                  num_in = '0;
                  state_in = ST_ROW;
               end
            end
         end
         ST_LRD: state_in = ST_LWR;
         ST_LWR: begin
            wr_en = 1'b1;
            if (item_ff.x == '0) wr_data = StoreWidth'(item_ff.sample);
            state_in = ST_IDLE;
         end
         ST_ROW: begin
            if (k_ff > zhi_ff || j_ff > yhi_ff) begin
               state_in = ST_DIV;
            end else if (rem < 13'sd0) begin
               state_in = ST_ACC;
            end else begin
               sq_start = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_done) begin
               i0_in = (t0 < 9'sd0) ? 8'sd0 : 8'(t0);
               i1_in = (t1 > sx - 9'sd1) ? 8'(sx - 9'sd1) : 8'(t1);
               if (((t1 > sx - 9'sd1) ? sx - 9'sd1 : t1) < ((t0 < 9'sd0) ? 9'sd0 : t0))
                  state_in = ST_ACC;
               else state_in = ST_RDHI;
            end
         end
         ST_RDHI: begin
            rd_addr = {ZW'(k_ff), YW'(j_ff), XW'(i1_ff)};
            state_in = ST_RDLO;
         end
         ST_RDLO: begin
            hi_in = rd_data_ff;
            rd_addr = {ZW'(k_ff), YW'(j_ff), XW'(i0_ff - 8'sd1)};
            state_in = ST_ACC;
            num_in = num_ff + CountWidth'(i1_ff - i0_ff + 8'sd1);
         end
         ST_ACC: begin
            if (acc_row_ff) sum_in = sum_ff + SumWidth'(StoreWidth'(hi_ff - lo_val));
            state_in = ST_ROW;
            if (j_ff >= yhi_ff) begin
               j_in = ylo_ff;
               k_in = k_ff + 8'sd1;
            end else begin
               j_in = j_ff + 8'sd1;
            end
         end
         ST_DIV: begin
            if (!rsp_valid_ff) begin
               if (num_ff == '0) begin
                  rsp_in.mean = '0;
                  rsp_in.count = '0;
                  state_in = ST_OUT;
               end else begin
                  div_ctrl.start = 1'b1;
                  state_in = ST_DIVW;
               end
            end
         end
         ST_DIVW: begin
            div_ctrl.busy = 1'b1;
            if (div_done) begin
               rsp_in.mean = (div_q > DW'(24'hFFFFFF)) ? 24'hFFFFFF : MeanWidth'(div_q);
               rsp_in.count = num_ff;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_row_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_row_ff <= (state_ff == ST_RDLO);
      end
      item_ff <= item_in;
      j_ff <= j_in; k_ff <= k_in; ylo_ff <= ylo_in; yhi_ff <= yhi_in; zhi_ff <= zhi_in;
      i0_ff <= i0_in; i1_ff <= i1_in; hi_ff <= hi_in;
      num_ff <= num_in;
      sum_ff <= sum_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_ctrl.busy) else $error("ready while dividing");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_payload)) else $error("response changed");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
endmodule
`default_nettype wire
